### design/dk_pkg.sv
// shared types and constants for the dijet kinematics pipeline
package dk_pkg;

  localparam int ETA_BITS          = 12;
  localparam int PHI_BITS          = 16;
  localparam int MASS_BITS         = 21;
  localparam int MOMENTUM_BITS_DEF = 20;

  localparam logic [MASS_BITS-1:0] MASS_MAX = {MASS_BITS{1'b1}};

  // per-pair results that ride along with the mass computation
  typedef struct packed {
    logic                opposite;
    logic [ETA_BITS-1:0] eta_gap;
    logic [PHI_BITS-1:0] phi_gap;
    logic                invalid;
  } side_t;

endpackage

### design/dk_prep.sv
// front pipeline: momentum sums, magnitudes, squares and mass squared
module dk_prep #(
  parameter int MOMENTUM_BITS = dk_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dk_pkg::ETA_BITS-1:0]      first_eta,
  input  logic        [dk_pkg::PHI_BITS-1:0]      first_phi,
  input  logic signed [MOMENTUM_BITS-1:0]        first_px,
  input  logic signed [MOMENTUM_BITS-1:0]        first_py,
  input  logic signed [MOMENTUM_BITS-1:0]        first_pz,
  input  logic        [MOMENTUM_BITS-1:0]        first_energy,
  input  logic signed [dk_pkg::ETA_BITS-1:0]      second_eta,
  input  logic        [dk_pkg::PHI_BITS-1:0]      second_phi,
  input  logic signed [MOMENTUM_BITS-1:0]        second_px,
  input  logic signed [MOMENTUM_BITS-1:0]        second_py,
  input  logic signed [MOMENTUM_BITS-1:0]        second_pz,
  input  logic        [MOMENTUM_BITS-1:0]        second_energy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output dk_pkg::side_t                          out_side,
  output logic        [2*MOMENTUM_BITS+1:0]      out_rad
);

  localparam int SB = MOMENTUM_BITS + 1;
  localparam int QB = 2 * MOMENTUM_BITS + 2;
  localparam int EB = dk_pkg::ETA_BITS;
  localparam int PB = dk_pkg::PHI_BITS;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1 comb
  logic [SB-1:0]   sx_next, sy_next, sz_next, se_next;
  logic [EB:0]     de;
  logic [EB:0]     de_abs;
  logic [PB-1:0]   dphi;
  logic            pos0, neg0, pos1, neg1;
  dk_pkg::side_t   side_next;

  // stage registers
  logic [SB-1:0]   sx1, sy1, sz1, se1;
  dk_pkg::side_t   side1, side2, side3, side4, side5;
  logic [SB-1:0]   ax2, ay2, az2, se2;
  logic [QB-1:0]   x3, y3, z3, e3;
  logic [QB-1:0]   psq4, esq4;
  logic [QB-1:0]   rad5;

  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sx_next = {first_px[MOMENTUM_BITS-1], first_px} + {second_px[MOMENTUM_BITS-1], second_px};
    sy_next = {first_py[MOMENTUM_BITS-1], first_py} + {second_py[MOMENTUM_BITS-1], second_py};
    sz_next = {first_pz[MOMENTUM_BITS-1], first_pz} + {second_pz[MOMENTUM_BITS-1], second_pz};
    se_next = {1'b0, first_energy} + {1'b0, second_energy};
    de      = {first_eta[EB-1], first_eta} - {second_eta[EB-1], second_eta};
    de_abs  = de[EB] ? (~de + 1'b1) : de;
    dphi    = first_phi - second_phi;
    // zero eta sits on neither side
    pos0    = !first_eta[EB-1] && (first_eta != '0);
    neg0    = first_eta[EB-1];
    pos1    = !second_eta[EB-1] && (second_eta != '0);
    neg1    = second_eta[EB-1];
    side_next.opposite = (pos0 && neg1) || (neg0 && pos1);
    side_next.eta_gap  = de_abs[EB-1:0];
    // half a turn maps onto itself
    side_next.phi_gap  = dphi[PB-1] ? (~dphi + 1'b1) : dphi;
    side_next.invalid  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sx1   <= sx_next;
      sy1   <= sy_next;
      sz1   <= sz_next;
      se1   <= se_next;
      side1 <= side_next;
    end
    // magnitudes
    if (rdy2) begin
      ax2   <= sx1[SB-1] ? (~sx1 + 1'b1) : sx1;
      ay2   <= sy1[SB-1] ? (~sy1 + 1'b1) : sy1;
      az2   <= sz1[SB-1] ? (~sz1 + 1'b1) : sz1;
      se2   <= se1;
      side2 <= side1;
    end
    // squares
    if (rdy3) begin
      x3    <= ax2 * ax2;
      y3    <= ay2 * ay2;
      z3    <= az2 * az2;
      e3    <= se2 * se2;
      side3 <= side2;
    end
    if (rdy4) begin
      psq4  <= x3 + y3 + z3;
      esq4  <= e3;
      side4 <= side3;
    end
    // negative mass squared clamps to zero radicand
    if (rdy5) begin
      side5.opposite <= side4.opposite;
      side5.eta_gap  <= side4.eta_gap;
      side5.phi_gap  <= side4.phi_gap;
      side5.invalid  <= esq4 < psq4;
      rad5           <= (esq4 < psq4) ? '0 : (esq4 - psq4);
    end
  end

  assign out_valid = v5;
  assign out_side  = side5;
  assign out_rad   = rad5;

endmodule

### design/dk_sqrt_step.sv
// one pipelined digit of the integer square root
module dk_sqrt_step #(
  parameter int ROOT_BITS = dk_pkg::MOMENTUM_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  dk_pkg::side_t            in_side,
  input  logic [2*ROOT_BITS-1:0]   in_rad,
  input  logic [ROOT_BITS:0]       in_rem,
  input  logic [ROOT_BITS-1:0]     in_root,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dk_pkg::side_t            out_side,
  output logic [2*ROOT_BITS-1:0]   out_rad,
  output logic [ROOT_BITS:0]       out_rem,
  output logic [ROOT_BITS-1:0]     out_root
);

  logic [ROOT_BITS+2:0] rem_sh;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 take;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh = {in_rem, in_rad[2*ROOT_BITS-1 -: 2]};
    trial  = {1'b0, in_root, 2'b01};
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_side <= in_side;
      out_rad  <= {in_rad[2*ROOT_BITS-3:0], 2'b00};
      out_rem  <= take ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
      out_root <= {in_root[ROOT_BITS-2:0], take};
    end
  end

endmodule

### design/dijet_kinematics_top.sv
// top level of the dijet kinematics pipeline
// One jet pair enters per beat and one result beat leaves per pair, in order. The pipeline
// is 5 + MOMENTUM_BITS + 1 register stages deep: five front stages form the momentum sums,
// magnitudes, squares and mass squared, then one stage per root bit runs a restoring square
// root. Every stage has its own valid bit and takes a new beat whenever it is empty or its
// successor moves, so a pair can enter on every cycle and a stalled output only backs up as
// far as the pipeline is full; sustained throughput is one pair per cycle while out_ready
// stays high. The eta and phi results ride alongside the mass. An eta of exactly zero is on
// neither side, a half-turn phi difference reports 32768, and a negative mass squared gives
// mass 0 with mass_invalid set. With MOMENTUM_BITS above 20 the mass saturates at its
// 21-bit maximum.
module dijet_kinematics_top #(
  parameter int MOMENTUM_BITS = dk_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dk_pkg::ETA_BITS-1:0]      first_eta,
  input  logic        [dk_pkg::PHI_BITS-1:0]      first_phi,
  input  logic signed [MOMENTUM_BITS-1:0]        first_px,
  input  logic signed [MOMENTUM_BITS-1:0]        first_py,
  input  logic signed [MOMENTUM_BITS-1:0]        first_pz,
  input  logic        [MOMENTUM_BITS-1:0]        first_energy,
  input  logic signed [dk_pkg::ETA_BITS-1:0]      second_eta,
  input  logic        [dk_pkg::PHI_BITS-1:0]      second_phi,
  input  logic signed [MOMENTUM_BITS-1:0]        second_px,
  input  logic signed [MOMENTUM_BITS-1:0]        second_py,
  input  logic signed [MOMENTUM_BITS-1:0]        second_pz,
  input  logic        [MOMENTUM_BITS-1:0]        second_energy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   opposite_sides,
  output logic        [dk_pkg::ETA_BITS-1:0]      eta_gap,
  output logic        [dk_pkg::PHI_BITS-1:0]      phi_gap,
  output logic        [dk_pkg::MASS_BITS-1:0]     pair_mass,
  output logic                                   mass_invalid
);

  // root of a (2*MOMENTUM_BITS+2)-bit mass squared
  localparam int RB = MOMENTUM_BITS + 1;
  localparam int MB = dk_pkg::MASS_BITS;

  // chain between square root digits, index 0 is the front pipeline output
  logic                valid_c [0:RB];
  logic                ready_c [0:RB];
  dk_pkg::side_t       side_c  [0:RB];
  logic [2*RB-1:0]     rad_c   [0:RB];
  logic [RB:0]         rem_c   [0:RB];
  logic [RB-1:0]       root_c  [0:RB];

  dk_prep #(
    .MOMENTUM_BITS (MOMENTUM_BITS)
  ) u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_eta     (first_eta),
    .first_phi     (first_phi),
    .first_px      (first_px),
    .first_py      (first_py),
    .first_pz      (first_pz),
    .first_energy  (first_energy),
    .second_eta    (second_eta),
    .second_phi    (second_phi),
    .second_px     (second_px),
    .second_py     (second_py),
    .second_pz     (second_pz),
    .second_energy (second_energy),
    .out_valid     (valid_c[0]),
    .out_ready     (ready_c[0]),
    .out_side      (side_c[0]),
    .out_rad       (rad_c[0])
  );

  // remainder and partial root start at zero
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    dk_sqrt_step #(
      .ROOT_BITS (RB)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[i]),
      .in_ready  (ready_c[i]),
      .in_side   (side_c[i]),
      .in_rad    (rad_c[i]),
      .in_rem    (rem_c[i]),
      .in_root   (root_c[i]),
      .out_valid (valid_c[i+1]),
      .out_ready (ready_c[i+1]),
      .out_side  (side_c[i+1]),
      .out_rad   (rad_c[i+1]),
      .out_rem   (rem_c[i+1]),
      .out_root  (root_c[i+1])
    );
  end

  // last digit stage doubles as the output register
  assign ready_c[RB] = out_ready;
  assign out_valid   = valid_c[RB];

  // clamp the root to the 21-bit result when the momentum width allows more
  if (RB > MB) begin : g_sat
    assign pair_mass = (root_c[RB] > RB'(dk_pkg::MASS_MAX)) ? dk_pkg::MASS_MAX
                                                            : root_c[RB][MB-1:0];
  end else begin : g_nosat
    assign pair_mass = MB'(root_c[RB]);
  end

  assign opposite_sides = side_c[RB].opposite;
  assign eta_gap        = side_c[RB].eta_gap;
  assign phi_gap        = side_c[RB].phi_gap;
  assign mass_invalid   = side_c[RB].invalid;

  // negative mass squared must leave a zero root
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && mass_invalid |-> pair_mass == '0)
    else $error("invalid mass with nonzero root");

  // wrapped azimuth gap never exceeds half a turn
  a_phi_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phi_gap <= 16'h8000)
    else $error("phi gap above half turn");

  // opposite hemispheres imply a nonzero eta gap
  a_opp_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && opposite_sides |-> eta_gap != '0)
    else $error("opposite sides with zero eta gap");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule
